>>> rtl/wpm_pkg.sv
package wpm_pkg;

  localparam int OpcodeW = 2;
  localparam int SymbolW = 8;

  localparam logic [OpcodeW-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OpcodeW-1:0] OP_APPEND = 2'd1;
  localparam logic [OpcodeW-1:0] OP_TEXT   = 2'd2;
  localparam logic [OpcodeW-1:0] OP_QUERY  = 2'd3;

  localparam logic [SymbolW-1:0] SYM_STAR = 8'd42;
  localparam logic [SymbolW-1:0] SYM_ANY  = 8'd63;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [SymbolW-1:0] symbol;
  } cmd_t;

  typedef struct packed {
    logic matched;
    logic misuse;
  } res_t;

endpackage

>>> rtl/wildcard_pattern_matcher.sv
// Wildcard pattern matcher: a pattern of up to MAX_PATTERN bytes is appended one symbol at a
// time, where '?' matches any one byte and '*' any run including an empty one; text bytes then
// stream in and each text word and each query word returns one result word telling whether the
// text so far matches the whole pattern, together with a sticky misuse flag (pattern overflow or
// an append after text has started). Clear and append words return nothing. The block takes one
// word per clock cycle unless a text or query word waits on a stalled, full output register:
// the command goes through an input register, then the whole match row (one bit per pattern
// prefix) updates combinationally through a parallel prefix over runs of stars, and the result
// sits in an output register that is refilled in the same cycle it is taken.
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  wpm_pkg::cmd_t   cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output wpm_pkg::res_t   res
);
  import wpm_pkg::*;

  localparam int LenW = $clog2(MAX_PATTERN + 1);
  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int Lvls = $clog2(MAX_PATTERN + 1);

  logic [SymbolW-1:0] pattern_store [MAX_PATTERN];
  logic [LenW-1:0]    pattern_length, pattern_length_next;
  logic [MAX_PATTERN:0] match_row, match_row_next;
  logic text_started, text_started_next;
  logic misuse_flag, misuse_flag_next;

  logic in_valid;
  cmd_t in_cmd;
  logic produces, advance, store_we;
  logic [LenW-1:0] len_plus;
  logic matched_next;

  logic [Lvls:0][MAX_PATTERN:0] gen, prop;
  logic [MAX_PATTERN:0] text_row;

  assign produces  = (in_cmd.opcode == OP_TEXT) || (in_cmd.opcode == OP_QUERY);
  assign advance   = in_valid && (!produces || !res_valid || !res_stall);
  assign cmd_stall = in_valid && !advance;
  assign len_plus  = pattern_length + LenW'(1);

  // text row: next[j] = g[j] | p[j] & next[j-1], done as a log-depth prefix
  always_comb begin
    gen[0] = '0;
    prop[0] = '0;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      if (LenW'(j) <= pattern_length) begin
        if (pattern_store[j-1] == SYM_STAR) begin
          gen[0][j]  = match_row[j];
          prop[0][j] = 1'b1;
        end else begin
          gen[0][j] = match_row[j-1] &&
                      ((pattern_store[j-1] == SYM_ANY) || (pattern_store[j-1] == in_cmd.symbol));
        end
      end
    end
    for (int l = 0; l < Lvls; l++) begin
      for (int i = 0; i <= MAX_PATTERN; i++) begin
        if (i >= (1 << l)) begin
          gen[l+1][i]  = gen[l][i] | (prop[l][i] & gen[l][i - (1 << l)]);
          prop[l+1][i] = prop[l][i] & prop[l][i - (1 << l)];
        end else begin
          gen[l+1][i]  = gen[l][i];
          prop[l+1][i] = prop[l][i];
        end
      end
    end
    text_row = gen[Lvls];
  end

  always_comb begin
    pattern_length_next = pattern_length;
    match_row_next      = match_row;
    text_started_next   = text_started;
    misuse_flag_next    = misuse_flag;
    store_we            = 1'b0;
    if (advance) begin
      case (in_cmd.opcode)
        OP_CLEAR: begin
          pattern_length_next = '0;
          match_row_next      = (MAX_PATTERN + 1)'(1);
          text_started_next   = 1'b0;
          misuse_flag_next    = 1'b0;
        end
        OP_APPEND: begin
          if (text_started || (pattern_length >= LenW'(MAX_PATTERN))) begin
            misuse_flag_next = 1'b1;
          end else begin
            store_we = 1'b1;
            match_row_next[len_plus] = (in_cmd.symbol == SYM_STAR) && match_row[pattern_length];
            pattern_length_next = len_plus;
          end
        end
        OP_TEXT: begin
          match_row_next    = text_row;
          text_started_next = 1'b1;
        end
        OP_QUERY: begin
        end
        default: begin
        end
      endcase
    end
    matched_next = match_row_next[pattern_length];
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      pattern_store[pattern_length[IdxW-1:0]] <= in_cmd.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      res_valid      <= 1'b0;
      pattern_length <= '0;
      match_row      <= (MAX_PATTERN + 1)'(1);
      text_started   <= 1'b0;
      misuse_flag    <= 1'b0;
    end else begin
      pattern_length <= pattern_length_next;
      match_row      <= match_row_next;
      text_started   <= text_started_next;
      misuse_flag    <= misuse_flag_next;
      if (cmd_valid && !cmd_stall) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance && produces) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_cmd <= cmd;
    end
    if (advance && produces) begin
      res.matched <= matched_next;
      res.misuse  <= misuse_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> in_valid)
    else $error("stall raised with empty input register");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_length <= LenW'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_row_above_length: assert property (@(posedge clk) disable iff (rst)
    ((match_row >> pattern_length) >> 1) == '0)
    else $error("match bit set beyond pattern length");

  a_misuse_sticky: assert property (@(posedge clk) disable iff (rst)
    (misuse_flag && !(advance && (in_cmd.opcode == OP_CLEAR))) |=> misuse_flag)
    else $error("misuse flag dropped without clear");

  a_started_freezes_length: assert property (@(posedge clk) disable iff (rst)
    (text_started && !(advance && (in_cmd.opcode == OP_CLEAR))) |=> $stable(pattern_length))
    else $error("pattern grew after text started");
`endif

endmodule
